// File: design/opto_trem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optical tremolo gain: shared package
// Register map, reset values, fixed-point constants and the command
// encoding between the controller and the datapath.
// ----------------------------------------------------------------------------
package opto_trem_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd4;

  // Register reset values
  localparam logic [23:0] RST_RATE_STEP = 24'd4000;
  localparam logic [15:0] RST_DEPTH     = 16'd16384;
  localparam logic [16:0] RST_SMOOTH    = 17'd149;
  localparam logic [16:0] RST_ATTACK    = 17'd1000;
  localparam logic [16:0] RST_RELEASE   = 17'd100;

  // Fixed-point units
  localparam logic [16:0] COEF_ONE   = 17'd65536;  // Q1.16 one
  localparam logic [16:0] GAIN_ONE   = 17'd32768;  // Q1.15 one
  localparam logic [15:0] DEPTH_FULL = 16'd32768;  // Q1.15 full depth

  // Raised cosine table generation, Q30
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CELL,
    ST_DEPTH_HI,
    ST_DEPTH_LO,
    ST_STEP_HI,
    ST_GAIN,
    ST_STEP_LO,
    ST_SCALE,
    ST_FINISH
  } state_t;

  // Operand pair presented to the shared multiplier
  typedef enum logic [2:0] {
    MUL_CELL,
    MUL_DEPTH_HI,
    MUL_DEPTH_LO,
    MUL_STEP_HI,
    MUL_GAIN,
    MUL_STEP_LO,
    MUL_SCALE
  } mul_op_t;

  // Register update fed by the last product
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_CELL,
    UPD_TEMP,
    UPD_DEPTH,
    UPD_GAIN,
    UPD_STEP,
    UPD_OUT
  } upd_t;

  typedef struct packed {
    logic    take_in;
    logic    mul_en;
    mul_op_t mul_op;
    upd_t    upd;
  } dp_cmd_t;

endpackage

// File: design/opto_trem_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optical tremolo gain: controller
// Sequences the shared multiplier through the per-sample schedule and owns
// the input stall and the output valid.
// ----------------------------------------------------------------------------
module opto_trem_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output opto_trem_pkg::dp_cmd_t cmd
);

  opto_trem_pkg::state_t state;
  opto_trem_pkg::state_t state_next;
  logic                  out_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= opto_trem_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall = (state != opto_trem_pkg::ST_IDLE);

  always_comb begin
    state_next  = state;
    out_set     = 1'b0;
    cmd.take_in = 1'b0;
    cmd.mul_en  = 1'b0;
    cmd.mul_op  = opto_trem_pkg::MUL_CELL;
    cmd.upd     = opto_trem_pkg::UPD_NONE;
    unique case (state)
      opto_trem_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next  = opto_trem_pkg::ST_CELL;
        end
      end
      opto_trem_pkg::ST_CELL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = opto_trem_pkg::MUL_CELL;
        state_next = opto_trem_pkg::ST_DEPTH_HI;
      end
      opto_trem_pkg::ST_DEPTH_HI: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = opto_trem_pkg::MUL_DEPTH_HI;
        cmd.upd    = opto_trem_pkg::UPD_CELL;
        state_next = opto_trem_pkg::ST_DEPTH_LO;
      end
      opto_trem_pkg::ST_DEPTH_LO: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = opto_trem_pkg::MUL_DEPTH_LO;
        cmd.upd    = opto_trem_pkg::UPD_TEMP;
        state_next = opto_trem_pkg::ST_STEP_HI;
      end
      opto_trem_pkg::ST_STEP_HI: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = opto_trem_pkg::MUL_STEP_HI;
        cmd.upd    = opto_trem_pkg::UPD_DEPTH;
        state_next = opto_trem_pkg::ST_GAIN;
      end
      opto_trem_pkg::ST_GAIN: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = opto_trem_pkg::MUL_GAIN;
        cmd.upd    = opto_trem_pkg::UPD_TEMP;
        state_next = opto_trem_pkg::ST_STEP_LO;
      end
      opto_trem_pkg::ST_STEP_LO: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = opto_trem_pkg::MUL_STEP_LO;
        cmd.upd    = opto_trem_pkg::UPD_GAIN;
        state_next = opto_trem_pkg::ST_SCALE;
      end
      opto_trem_pkg::ST_SCALE: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = opto_trem_pkg::MUL_SCALE;
        cmd.upd    = opto_trem_pkg::UPD_STEP;
        state_next = opto_trem_pkg::ST_FINISH;
      end
      opto_trem_pkg::ST_FINISH: begin
        // hold until the output register is free or being emptied
        if (!out_valid || !out_stall) begin
          cmd.upd    = opto_trem_pkg::UPD_OUT;
          out_set    = 1'b1;
          state_next = opto_trem_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = opto_trem_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/opto_trem_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optical tremolo gain: datapath
// Configuration registers, smoother/phase/cell state, raised cosine ROM,
// one shared signed multiplier and the output register.
// ----------------------------------------------------------------------------
module opto_trem_dp #(
  parameter int COS_TABLE_DEPTH = 1024,
  parameter int SAMPLE_WIDTH    = 24,
  parameter int PHASE_WIDTH     = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  opto_trem_pkg::dp_cmd_t               cmd,
  input  logic                                 cfg_wr,
  input  logic [opto_trem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [opto_trem_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
  output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
  output logic [15:0]                          gain_now
);

  localparam int AW   = (SAMPLE_WIDTH > 25) ? SAMPLE_WIDTH : 25;
  localparam int PRW  = AW + 18;
  localparam int IDXW = $clog2(COS_TABLE_DEPTH);
  localparam int IPW  = PHASE_WIDTH + IDXW;

  // cos(pi * j / N) in Q30 for 0 <= j <= N/2, degree 14 Taylor series
  function automatic logic signed [63:0] cos_quarter(input logic [63:0] j);
    logic [63:0]        th;
    logic [63:0]        th2;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    begin
      th  = (j * opto_trem_pkg::PI_Q30) / COS_TABLE_DEPTH;
      th2 = (th * th) >> 30;
      mag = opto_trem_pkg::ONE_Q30;
      sum = $signed(opto_trem_pkg::ONE_Q30);
      mag = ((mag * th2) >> 30) / 2;
      sum = sum - $signed(mag);
      mag = ((mag * th2) >> 30) / 12;
      sum = sum + $signed(mag);
      mag = ((mag * th2) >> 30) / 30;
      sum = sum - $signed(mag);
      mag = ((mag * th2) >> 30) / 56;
      sum = sum + $signed(mag);
      mag = ((mag * th2) >> 30) / 90;
      sum = sum - $signed(mag);
      mag = ((mag * th2) >> 30) / 132;
      sum = sum + $signed(mag);
      mag = ((mag * th2) >> 30) / 182;
      sum = sum - $signed(mag);
      return sum;
    end
  endfunction

  // Q1.16 raised cosine sample k, evaluated at elaboration
  function automatic logic [16:0] rc_entry(input int k);
    logic [63:0]        m;
    logic [63:0]        j;
    logic signed [63:0] c;
    logic signed [63:0] v;
    logic [63:0]        r;
    begin
      m = 64'(k);
      if (2 * m > 64'(COS_TABLE_DEPTH)) begin
        m = 64'(COS_TABLE_DEPTH) - m;
      end
      j = 2 * m;
      if (2 * j > 64'(COS_TABLE_DEPTH)) begin
        c = -cos_quarter(64'(COS_TABLE_DEPTH) - j);
      end else begin
        c = cos_quarter(j);
      end
      v = $signed(opto_trem_pkg::ONE_Q30) - c;
      if (v < 0) begin
        v = 0;
      end
      if (v > $signed(2 * opto_trem_pkg::ONE_Q30)) begin
        v = $signed(2 * opto_trem_pkg::ONE_Q30);
      end
      r = ($unsigned(v) + 64'd16384) >> 15;
      return r[16:0];
    end
  endfunction

  // Configuration
  logic [23:0] rate_target;
  logic [15:0] depth_target;
  logic [16:0] smooth_coeff;
  logic [16:0] attack_coeff;
  logic [16:0] release_coeff;

  // Filter state
  logic [39:0]            step_s;
  logic [31:0]            depth_s;
  logic [PHASE_WIDTH-1:0] phase;
  logic [16:0]            cell_lvl;
  logic [15:0]            gain;

  // Working registers
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic [16:0]                    lamp_q;
  logic signed [PRW-1:0]          prod_q;
  logic signed [41:0]             temp;

  logic [16:0] cos_rom [COS_TABLE_DEPTH];

  logic [16:0]        sc;
  logic [16:0]        cell_coef;
  logic [15:0]        dt;
  logic [15:0]        depth_use;
  logic signed [17:0] lamp_diff;
  logic signed [16:0] depth_diff;
  logic signed [24:0] step_diff;
  logic signed [AW-1:0] mul_a;
  logic signed [17:0]   mul_b;
  logic [33:0]        lo_round;
  logic [16:0]        ceil_lo;
  logic signed [18:0] cell_sum;
  logic signed [43:0] depth_sum;
  logic signed [43:0] step_sum;
  logic [32:0]        gain_round;
  logic [16:0]        gain_calc;
  logic [23:0]        step_int;
  logic [IPW-1:0]     idx_prod;
  logic [IDXW-1:0]    rom_addr;

  for (genvar k = 0; k < COS_TABLE_DEPTH; k++) begin : g_rom
    assign cos_rom[k] = rc_entry(k);
  end

  // Coefficients above one act as one; depth above full acts as full
  assign sc        = (smooth_coeff > opto_trem_pkg::COEF_ONE) ? opto_trem_pkg::COEF_ONE
                                                               : smooth_coeff;
  assign cell_coef = (lamp_q > cell_lvl)
                     ? ((attack_coeff > opto_trem_pkg::COEF_ONE) ? opto_trem_pkg::COEF_ONE
                                                                 : attack_coeff)
                     : ((release_coeff > opto_trem_pkg::COEF_ONE) ? opto_trem_pkg::COEF_ONE
                                                                  : release_coeff);
  assign dt        = (depth_target > opto_trem_pkg::DEPTH_FULL) ? opto_trem_pkg::DEPTH_FULL
                                                                 : depth_target;
  assign depth_use = (depth_s[31:16] > opto_trem_pkg::DEPTH_FULL) ? opto_trem_pkg::DEPTH_FULL
                                                                   : depth_s[31:16];

  assign lamp_diff  = $signed({1'b0, lamp_q}) - $signed({1'b0, cell_lvl});
  assign depth_diff = $signed({1'b0, dt}) - $signed({1'b0, depth_s[31:16]});
  assign step_diff  = $signed({1'b0, rate_target}) - $signed({1'b0, step_s[39:16]});

  always_comb begin
    mul_a = AW'(lamp_diff);
    mul_b = $signed({1'b0, cell_coef});
    unique case (cmd.mul_op)
      opto_trem_pkg::MUL_CELL: begin
        mul_a = AW'(lamp_diff);
        mul_b = $signed({1'b0, cell_coef});
      end
      opto_trem_pkg::MUL_DEPTH_HI: begin
        mul_a = AW'(depth_diff);
        mul_b = $signed({1'b0, sc});
      end
      opto_trem_pkg::MUL_DEPTH_LO: begin
        mul_a = AW'($signed({1'b0, depth_s[15:0]}));
        mul_b = $signed({1'b0, sc});
      end
      opto_trem_pkg::MUL_STEP_HI: begin
        mul_a = AW'(step_diff);
        mul_b = $signed({1'b0, sc});
      end
      opto_trem_pkg::MUL_GAIN: begin
        mul_a = AW'($signed({1'b0, depth_use}));
        mul_b = $signed({1'b0, cell_lvl});
      end
      opto_trem_pkg::MUL_STEP_LO: begin
        mul_a = AW'($signed({1'b0, step_s[15:0]}));
        mul_b = $signed({1'b0, sc});
      end
      opto_trem_pkg::MUL_SCALE: begin
        mul_a = AW'(sample_q);
        mul_b = $signed({2'b00, gain});
      end
      default: begin
        mul_a = AW'(lamp_diff);
        mul_b = $signed({1'b0, cell_coef});
      end
    endcase
  end

  // Low-half correction: floor(-x / 2^16) = -ceil(x / 2^16) for x >= 0
  assign lo_round   = {1'b0, prod_q[32:0]} + 34'd65535;
  assign ceil_lo    = lo_round[32:16];
  assign cell_sum   = $signed({2'b00, cell_lvl}) + 19'(prod_q >>> 16);
  assign depth_sum  = $signed({12'd0, depth_s}) + 44'(temp) - $signed({27'd0, ceil_lo});
  assign step_sum   = $signed({4'd0, step_s}) + 44'(temp) - $signed({27'd0, ceil_lo});
  assign gain_round = {1'b0, prod_q[31:0]} + 33'd32768;
  assign gain_calc  = opto_trem_pkg::GAIN_ONE - gain_round[32:16];
  assign step_int   = step_s[39:16];
  assign idx_prod   = IPW'(phase) * IPW'(COS_TABLE_DEPTH);
  assign rom_addr   = idx_prod[IPW-1:PHASE_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_target   <= opto_trem_pkg::RST_RATE_STEP;
      depth_target  <= opto_trem_pkg::RST_DEPTH;
      smooth_coeff  <= opto_trem_pkg::RST_SMOOTH;
      attack_coeff  <= opto_trem_pkg::RST_ATTACK;
      release_coeff <= opto_trem_pkg::RST_RELEASE;
      step_s        <= {opto_trem_pkg::RST_RATE_STEP, 16'd0};
      depth_s       <= {opto_trem_pkg::RST_DEPTH, 16'd0};
      phase         <= '0;
      cell_lvl      <= '0;
      gain          <= opto_trem_pkg::DEPTH_FULL;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          opto_trem_pkg::CFG_RATE_STEP: rate_target   <= cfg_data;
          opto_trem_pkg::CFG_DEPTH:     depth_target  <= cfg_data[15:0];
          opto_trem_pkg::CFG_SMOOTH:    smooth_coeff  <= cfg_data[16:0];
          opto_trem_pkg::CFG_ATTACK:    attack_coeff  <= cfg_data[16:0];
          opto_trem_pkg::CFG_RELEASE:   release_coeff <= cfg_data[16:0];
          default: ;
        endcase
      end
      case (cmd.upd)
        opto_trem_pkg::UPD_CELL:  cell_lvl <= cell_sum[16:0];
        opto_trem_pkg::UPD_DEPTH: depth_s  <= depth_sum[31:0];
        opto_trem_pkg::UPD_GAIN:  gain     <= gain_calc[15:0];
        opto_trem_pkg::UPD_STEP:  step_s   <= step_sum[39:0];
        opto_trem_pkg::UPD_OUT:   phase    <= phase + PHASE_WIDTH'(step_int >> (32 - PHASE_WIDTH));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      sample_q <= sample_in;
      lamp_q   <= cos_rom[rom_addr];
    end
    if (cmd.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd.upd == opto_trem_pkg::UPD_TEMP) begin
      temp <= 42'(prod_q);
    end
    if (cmd.upd == opto_trem_pkg::UPD_OUT) begin
      sample_out <= SAMPLE_WIDTH'(prod_q >>> 15);
      gain_now   <= gain;
    end
  end

endmodule

// File: design/opto_tremolo_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optical tremolo gain
// Scales each audio sample by 1 - depth * cell, where the cell level follows
// a raised cosine LFO lamp with separate attack and release rates, and the
// LFO step and depth glide toward their targets through one-pole smoothers.
// ----------------------------------------------------------------------------
//
//  channel | handshake                    | payload
//  --------+------------------------------+------------------------------------
//  input   | in_valid / in_stall (out)    | sample_in
//  output  | out_valid / out_stall (in)   | sample_out, gain_now
//  config  | cfg_valid / cfg_ready (out)  | cfg_index, cfg_data
//
//  Each item runs in order: capture the sample and read the cosine ROM,
//  then seven passes through the single shared multiplier and one
//  write-back step. in_stall stays high outside idle, so the block takes
//  no new sample until it is through with the last one.
//  rst is synchronous; it restores the register reset values and the filter
//  state with no clearing pass. A stalled result holds in the output
//  register; the block still takes the next sample and parks it in the last
//  step until the output register frees up.
//
module opto_tremolo_gain #(
  parameter int COS_TABLE_DEPTH = 1024,
  parameter int SAMPLE_WIDTH    = 24,
  parameter int PHASE_WIDTH     = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // sample input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
  output logic [15:0]                          gain_now,
  // register writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [opto_trem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [opto_trem_pkg::CFG_DATA_W-1:0] cfg_data
);

  opto_trem_pkg::dp_cmd_t cmd;

  // Registers take a write in any cycle; the user is to land writes only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  // Sequence the schedule: cell, depth (hi/lo), step hi, gain, step lo, scale.
  opto_trem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Hold all arithmetic state, the ROM and the output register.
  opto_trem_dp #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .PHASE_WIDTH     (PHASE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_wr     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .sample_out (sample_out),
    .gain_now   (gain_now)
  );

endmodule

// File: dv/opto_tremolo_gain_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optical tremolo gain: result checker
// Watches the register, sample and result channels. Keeps its own copy of the
// smoothers, LFO phase and opto cell. Predicts the scaled sample and gain for
// every sample transfer, and compares each result transfer against the oldest
// prediction.
// ----------------------------------------------------------------------------
module opto_tremolo_gain_checker #(
  parameter int COS_DEPTH = 1024,
  parameter int SAMPLE_W  = 24,
  parameter int PHASE_W   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [SAMPLE_W-1:0]           sample_in,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [SAMPLE_W-1:0]           sample_out,
  input  logic [15:0]                          gain_now,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [opto_trem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [opto_trem_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                   errors,
  output int                                   pending
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] audio;
    logic [15:0]                gain;
  } tremolo_out_t;

  // register copy
  logic [23:0]        rate_tgt;
  logic [15:0]        depth_tgt;
  logic [16:0]        smooth_k;
  logic [16:0]        attack_k;
  logic [16:0]        rel_k;
  // filter state
  logic [39:0]        step_lvl;
  logic [31:0]        depth_lvl;
  logic [PHASE_W-1:0] phase;
  logic [16:0]        cell_lvl;
  logic [16:0]        lamp_rom [COS_DEPTH];

  tremolo_out_t scaled_q[$];
  int           bad_count = 0;
  int           open_count = 0;

  assign errors  = bad_count;
  assign pending = open_count;

  // cos(pi * j / n) in Q30 from a degree-14 Taylor series
  function automatic longint cos_q30(input longint unsigned j, input longint unsigned n);
    longint unsigned th;
    longint unsigned th2;
    longint unsigned term;
    longint          acc;
    int              i;
    th   = (j * opto_trem_pkg::PI_Q30) / n;
    th2  = (th * th) >> 30;
    term = opto_trem_pkg::ONE_Q30;
    acc  = opto_trem_pkg::ONE_Q30;
    for (i = 1; i <= 7; i++) begin
      term = ((term * th2) >> 30) / ((2 * i - 1) * (2 * i));
      if (i % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    return acc;
  endfunction

  // raised cosine entry k of n, Q1.16, folded onto the first quarter
  function automatic logic [16:0] lamp_entry(input longint unsigned k,
                                             input longint unsigned n);
    longint unsigned m;
    longint unsigned j;
    longint          c;
    longint          v;
    longint          one;
    one = opto_trem_pkg::ONE_Q30;
    m   = k;
    if (2 * m > n) m = n - m;
    j = 2 * m;
    if (2 * j > n) c = -cos_q30(n - j, n);
    else c = cos_q30(j, n);
    v = one - c;
    if (v < 0) v = 0;
    if (v > 2 * one) v = 2 * one;
    return 17'((v + (longint'(1) << 14)) >> 15);
  endfunction

  function automatic longint unsigned clamp_k(input logic [16:0] k);
    return (k > opto_trem_pkg::COEF_ONE) ? opto_trem_pkg::COEF_ONE : k;
  endfunction

  // one-pole move toward goal, floor rounding
  function automatic longint unsigned glide(input longint unsigned lvl,
                                            input longint unsigned goal,
                                            input longint unsigned k);
    longint sl;
    longint sg;
    longint sk;
    longint d;
    sl = lvl;
    sg = goal;
    sk = k;
    d  = sg - sl;
    return sl + ((d * sk) >>> 16);
  endfunction

  function automatic tremolo_out_t advance_tremolo(input logic signed [SAMPLE_W-1:0] x);
    longint unsigned sk;
    longint unsigned dgoal;
    longint unsigned p;
    longint unsigned idx;
    longint unsigned lamp;
    longint unsigned ak;
    longint unsigned dep;
    longint          s;
    longint          g;
    tremolo_out_t    r;
    sk    = clamp_k(smooth_k);
    dgoal = (depth_tgt > opto_trem_pkg::DEPTH_FULL) ? opto_trem_pkg::DEPTH_FULL : depth_tgt;
    step_lvl  = 40'(glide(step_lvl, {rate_tgt, 16'h0}, sk));
    depth_lvl = 32'(glide(depth_lvl, dgoal << 16, sk));
    // lamp at the old phase, then advance
    p   = phase;
    idx = (p * COS_DEPTH) >> PHASE_W;
    if (idx >= COS_DEPTH) idx = COS_DEPTH - 1;
    lamp  = lamp_rom[idx];
    phase = PHASE_W'(phase + ((step_lvl >> 16) >> (32 - PHASE_W)));
    ak       = clamp_k((lamp > cell_lvl) ? attack_k : rel_k);
    cell_lvl = 17'(glide(cell_lvl, lamp, ak));
    dep = depth_lvl >> 16;
    if (dep > opto_trem_pkg::DEPTH_FULL) dep = opto_trem_pkg::DEPTH_FULL;
    g = opto_trem_pkg::GAIN_ONE - ((dep * cell_lvl + opto_trem_pkg::GAIN_ONE) >> 16);
    s = x;
    r.audio = SAMPLE_W'((s * g) >>> 15);
    r.gain  = g[15:0];
    return r;
  endfunction

  initial begin
    for (int k = 0; k < COS_DEPTH; k++) lamp_rom[k] = lamp_entry(k, COS_DEPTH);
  end

  task automatic flag_result(input string why, input tremolo_out_t want,
                             input tremolo_out_t got);
    bad_count++;
    if (bad_count <= 10)
      $display("%0t: %s: sample_out exp %0d got %0d, gain_now exp %0d got %0d",
               $time, why, want.audio, got.audio, want.gain, got.gain);
  endtask

  always @(posedge clk) begin
    tremolo_out_t got;
    tremolo_out_t want;
    if (rst) begin
      rate_tgt  = opto_trem_pkg::RST_RATE_STEP;
      depth_tgt = opto_trem_pkg::RST_DEPTH;
      smooth_k  = opto_trem_pkg::RST_SMOOTH;
      attack_k  = opto_trem_pkg::RST_ATTACK;
      rel_k     = opto_trem_pkg::RST_RELEASE;
      step_lvl  = {opto_trem_pkg::RST_RATE_STEP, 16'h0};
      depth_lvl = {opto_trem_pkg::RST_DEPTH, 16'h0};
      phase     = '0;
      cell_lvl  = '0;
      scaled_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          opto_trem_pkg::CFG_RATE_STEP: rate_tgt  = cfg_data[23:0];
          opto_trem_pkg::CFG_DEPTH:     depth_tgt = cfg_data[15:0];
          opto_trem_pkg::CFG_SMOOTH:    smooth_k  = cfg_data[16:0];
          opto_trem_pkg::CFG_ATTACK:    attack_k  = cfg_data[16:0];
          opto_trem_pkg::CFG_RELEASE:   rel_k     = cfg_data[16:0];
          default: ;
        endcase
      end
      // compare before pushing so a result can never match its own sample
      if (out_valid && !out_stall) begin
        got.audio = sample_out;
        got.gain  = gain_now;
        if (scaled_q.size() == 0) begin
          want = '0;
          flag_result("result with nothing pending", want, got);
        end else begin
          want = scaled_q.pop_front();
          if (got.audio !== want.audio || got.gain !== want.gain)
            flag_result("result differs", want, got);
        end
      end
      if (in_valid && !in_stall) scaled_q.push_back(advance_tremolo(sample_in));
    end
    open_count = scaled_q.size();
  end

endmodule

// File: dv/opto_tremolo_gain_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optical tremolo gain: testbench top
// Drives samples and register writes into the tremolo gain stage, stalls the
// result side at random, and leaves prediction and comparison to the checker.
// A short directed pass covers sample extremes and coefficient and depth
// corner settings; random phases follow, each under a fresh register setting.
// ----------------------------------------------------------------------------
module opto_tremolo_gain_tb;

  localparam int SAMPLE_W     = 24;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_LEN     = 300;   // receiver hold-off, in cycles
  localparam int PHASE_ITEMS  = 80;
  localparam int PHASE_COUNT  = 6;

  typedef enum int {RX_RANDOM, RX_OPEN, RX_HOLD} rx_mode_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic signed [SAMPLE_W-1:0]           sample_in = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]           sample_out;
  logic [15:0]                          gain_now;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [opto_trem_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [opto_trem_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int       errors;
  int       pending;
  rx_mode_t rx_mode = RX_RANDOM;
  bit       tx_steady = 1'b0;   // sender offers back to back when set
  int       hold_count = 0;
  int       cycles = 0;

  always #5 clk = ~clk;

  opto_tremolo_gain dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .gain_now   (gain_now),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  opto_tremolo_gain_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .gain_now   (gain_now),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending)
  );

  // Result side: stall about one cycle in five, hold off for a long stretch
  // in hold mode (counted here), and never stall in open mode.
  always @(negedge clk) begin
    if (rx_mode == RX_HOLD) begin
      out_stall  <= (hold_count < HOLD_LEN);
      hold_count <= hold_count + 1;
    end else begin
      hold_count <= 0;
      if (rx_mode == RX_OPEN) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < 20);
    end
  end

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one sample, with random gaps ahead of it unless the sender is
  // steady. Hold the payload until the transfer completes.
  task automatic put_sample(input logic [SAMPLE_W-1:0] value);
    while (!tx_steady && $urandom_range(99) < 20) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    sample_in <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted result has come back.
  // Returns just after a rising edge.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [opto_trem_pkg::CFG_IDX_W-1:0] idx,
                           input logic [opto_trem_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all five registers, then release the write channel.
  task automatic program_regs(input logic [opto_trem_pkg::CFG_DATA_W-1:0] rate,
                              input logic [opto_trem_pkg::CFG_DATA_W-1:0] depth,
                              input logic [opto_trem_pkg::CFG_DATA_W-1:0] smooth,
                              input logic [opto_trem_pkg::CFG_DATA_W-1:0] attack,
                              input logic [opto_trem_pkg::CFG_DATA_W-1:0] rel);
    write_reg(opto_trem_pkg::CFG_RATE_STEP, rate);
    write_reg(opto_trem_pkg::CFG_DEPTH, depth);
    write_reg(opto_trem_pkg::CFG_SMOOTH, smooth);
    write_reg(opto_trem_pkg::CFG_ATTACK, attack);
    write_reg(opto_trem_pkg::CFG_RELEASE, rel);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Coefficients: instant, above one, anywhere, or slow. Junk in the
  // unused upper data bits.
  function automatic logic [opto_trem_pkg::CFG_DATA_W-1:0] pick_coeff();
    logic [16:0] k;
    logic [31:0] junk;
    junk = $urandom;
    case ($urandom_range(3))
      0: k = opto_trem_pkg::COEF_ONE;
      1: k = 17'($urandom_range(131071, 65537));
      2: k = 17'($urandom_range(65535));
      default: k = 17'($urandom_range(4095, 16));
    endcase
    return {junk[6:0], k};
  endfunction

  function automatic logic [opto_trem_pkg::CFG_DATA_W-1:0] pick_depth();
    logic [15:0] d;
    logic [31:0] junk;
    junk = $urandom;
    case ($urandom_range(3))
      0: d = opto_trem_pkg::DEPTH_FULL;
      1: d = 16'($urandom_range(65535));
      2: d = '0;
      default: d = 16'($urandom_range(32768));
    endcase
    return {junk[7:0], d};
  endfunction

  // Fast rates sweep the lamp through a good part of its cycle per phase.
  function automatic logic [opto_trem_pkg::CFG_DATA_W-1:0] pick_rate();
    logic [31:0] r;
    case ($urandom_range(3))
      0: r = 32'hFFFFFF;
      1: r = $urandom;
      2: r = $urandom_range(16777215, 8388608);
      default: r = $urandom_range(65535);
    endcase
    return r[23:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  initial begin
    int p;
    int n;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset setting: sample extremes, zero and the smallest magnitudes.
    put_sample(24'h7FFFFF);
    put_sample(24'h800000);
    put_sample(24'h000000);
    put_sample(24'hFFFFFF);
    put_sample(24'h000001);
    drain_results();

    // Everything instant, full depth, fastest rate: the cell tracks the
    // lamp exactly and the gain swings hard from one sample to the next.
    program_regs(24'hFFFFFF, {8'h0, opto_trem_pkg::DEPTH_FULL},
                 {7'h0, opto_trem_pkg::COEF_ONE}, {7'h0, opto_trem_pkg::COEF_ONE},
                 {7'h0, opto_trem_pkg::COEF_ONE});
    put_sample(24'h7FFFFF);
    put_sample(24'h800000);
    put_sample(24'h7FFFFF);
    put_sample(24'h800000);
    put_sample(24'h555555);
    put_sample(24'hAAAAAA);
    drain_results();

    // Coefficients above one act as instant; depth above full acts as full.
    // Upper data bits set for depth and smoothing, so the unused ones must be dropped.
    program_regs(24'h800000, 24'hFFFFFF, 24'hFFFFFF, 24'h010001, 24'h01FFFF);
    // Writes to unmapped indexes must leave every register alone.
    for (int i = opto_trem_pkg::CFG_RELEASE + 1; i < 2 ** opto_trem_pkg::CFG_IDX_W; i++)
      write_reg(opto_trem_pkg::CFG_IDX_W'(i), opto_trem_pkg::CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
    put_sample(24'h7FFFFF);
    put_sample(24'h800000);
    put_sample(24'h123456);
    put_sample(24'hEDCBA9);
    put_sample(24'h400000);
    put_sample(24'hC00000);
    drain_results();

    // All zero: smoothers and cell freeze where they stand.
    program_regs('0, '0, '0, '0, '0);
    put_sample(24'h7FFFFF);
    put_sample(24'h800000);
    put_sample(24'h0F0F0F);
    put_sample(24'hF0F0F0);
    drain_results();

    // Random phases. Phase two runs with no gaps on either side; phase
    // four holds the result side off long enough to back the block up
    // while the sender keeps offering. Every phase ends with a full drain.
    for (p = 0; p < PHASE_COUNT; p++) begin
      if (p == 2) begin
        rx_mode   = RX_OPEN;
        tx_steady = 1'b1;
      end else if (p == 4) begin
        rx_mode   = RX_HOLD;
        tx_steady = 1'b1;
      end else begin
        rx_mode   = RX_RANDOM;
        tx_steady = 1'b0;
      end
      program_regs(pick_rate(), pick_depth(), pick_coeff(), pick_coeff(), pick_coeff());
      for (n = 0; n < PHASE_ITEMS; n++) put_sample(pick_sample());
      drain_results();
      rx_mode   = RX_RANDOM;
      tx_steady = 1'b0;
    end

    // Let any stray result show up before the verdict.
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
